### design/distance_vector_table_update_defines.svh
// ----------------------------------------------------------------------------
// Distance vector table update - assertion macros
// Shared property shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DVTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DVTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dvtu_pkg.sv
// ----------------------------------------------------------------------------
// dvtu_pkg
// Types and constants shared by the distance vector table update block.
// ----------------------------------------------------------------------------
package dvtu_pkg;

  localparam int NODE_W = 7;

  localparam logic [1:0] OP_LINK = 2'd0;
  localparam logic [1:0] OP_ADV  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [NODE_W-1:0] DIST_UNKNOWN   = 7'd127;
  localparam logic [NODE_W-1:0] DIST_MAX       = 7'd126;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } item_t;

  typedef struct packed {
    logic              known;
    logic [NODE_W-1:0] distance;
    logic [NODE_W-1:0] next_hop;
  } result_t;

  typedef enum logic [2:0] {
    KIND_LINK,
    KIND_ADV,
    KIND_READ,
    KIND_DIAG,
    KIND_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] hops;
    logic [NODE_W-1:0] next_hop;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### design/dvtu_ram.sv
// ----------------------------------------------------------------------------
// dvtu_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dvtu_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

### design/dvtu_front.sv
// ----------------------------------------------------------------------------
// dvtu_front
// Accepts input words, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module dvtu_front import dvtu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NODE_W-1:0] n_eff_i,
  input  logic              clearing_i,
  input  logic              push_i,
  input  item_t             item_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t                 q_mem_q [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CW-1:0]   count_q;
  logic                 a_ok, b_ok, keep, wr_en, rd_en;
  cmd_kind_e            kind;

  assign a_ok = (item_i.node_a != '0) && (item_i.node_a <= n_eff_i);
  assign b_ok = (item_i.node_b != '0) && (item_i.node_b <= n_eff_i);

  always_comb begin
    kind = KIND_ZERO;
    keep = 1'b0;
    case (item_i.opcode)
      OP_LINK: begin
        kind = KIND_LINK;
        keep = a_ok && b_ok && (item_i.node_a != item_i.node_b);
      end
      OP_ADV: begin
        kind = KIND_ADV;
        keep = a_ok && b_ok && (item_i.node_a != item_i.node_b);
      end
      OP_READ: begin
        keep = 1'b1;
        if (!(a_ok && b_ok)) begin
          kind = KIND_ZERO;
        end else if (item_i.node_a == item_i.node_b) begin
          kind = KIND_DIAG;
        end else begin
          kind = KIND_READ;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o      = (count_q == CMDQ_CW'(CMDQ_DEPTH)) || clearing_i;
  assign wr_en       = push_i && !full_o && keep;
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (!wr_en && rd_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem_q[wr_ptr_q] <= '{kind: kind, node_a: item_i.node_a, node_b: item_i.node_b};
    end
  end

endmodule

### design/dvtu_back.sv
// ----------------------------------------------------------------------------
// dvtu_back
// Sequencer over the distance / next-hop table: clear pass, link writes,
// vector merge per destination, entry reads and the result register.
// ----------------------------------------------------------------------------
module dvtu_back import dvtu_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NODE_W-1:0] n_eff_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              clearing_o,
  output logic              out_valid_o,
  output result_t           out_o,
  input  logic              out_pop_i
);

  localparam int ROWS  = (MAX_NODES < 127) ? MAX_NODES : 127;
  localparam int CW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * ROWS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_LINK_AB   = 3'd2;
  localparam logic [2:0] ST_LINK_BA   = 3'd3;
  localparam logic [2:0] ST_ADV       = 3'd4;
  localparam logic [2:0] ST_ADV_DRAIN = 3'd5;
  localparam logic [2:0] ST_RD_ADDR   = 3'd6;
  localparam logic [2:0] ST_RD_DATA   = 3'd7;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(int'(r) * ROWS + int'(c));
  endfunction

  function automatic logic [CW-1:0] node_idx(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - 7'd1;
    return CW'(m);
  endfunction

  logic [2:0]        state_q;
  cmd_t              cmd_q;
  logic [CW-1:0]     col_q, ex_col_q;
  logic              ex_valid_q;
  logic [AW-1:0]     clr_q;
  logic              out_valid_q;
  result_t           out_q;

  logic              out_free, head_instant, col_last;
  logic              ram_we;
  logic [AW-1:0]     waddr, raddr0, raddr1;
  entry_t            wdata, ent_a, ent_b;
  logic [ENTRY_W-1:0] rdata0, rdata1;
  logic [NODE_W-1:0] ex_node, da, cand;
  logic              ex_we, load_inst, load_rd;
  result_t           inst_res, rd_res;

  assign out_free     = !out_valid_q || out_pop_i;
  assign head_instant = (cmd_i.kind == KIND_DIAG) || (cmd_i.kind == KIND_ZERO);
  assign cmd_pop_o    = (state_q == ST_IDLE) && cmd_valid_i && (!head_instant || out_free);
  assign col_last     = (col_q == node_idx(n_eff_i));
  assign clearing_o   = (state_q == ST_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

  assign raddr0 = (state_q == ST_ADV) ? cell_addr(node_idx(cmd_q.node_a), col_q)
                                      : cell_addr(node_idx(cmd_q.node_a),
                                                  node_idx(cmd_q.node_b));
  assign raddr1 = cell_addr(node_idx(cmd_q.node_b), col_q);

  assign ent_a   = entry_t'(rdata0);
  assign ent_b   = entry_t'(rdata1);
  assign ex_node = NODE_W'(ex_col_q) + 7'd1;
  assign da      = (ex_node == cmd_q.node_a) ? '0 : ent_a.hops;
  assign cand    = (da >= DIST_MAX) ? DIST_MAX : da + 7'd1;
  assign ex_we   = ex_valid_q && (ex_node != cmd_q.node_b) && (da != DIST_UNKNOWN) &&
                   ((ent_b.hops == DIST_UNKNOWN) || (cand < ent_b.hops) ||
                    ((cand == ent_b.hops) && (ent_b.next_hop > cmd_q.node_a)));

  always_comb begin
    ram_we = 1'b0;
    waddr  = cell_addr(node_idx(cmd_q.node_a), node_idx(cmd_q.node_b));
    wdata  = '{hops: 7'd1, next_hop: cmd_q.node_b};
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        waddr  = clr_q;
        wdata  = '{hops: DIST_UNKNOWN, next_hop: '0};
      end
      ST_LINK_AB: begin
        ram_we = 1'b1;
      end
      ST_LINK_BA: begin
        ram_we = 1'b1;
        waddr  = cell_addr(node_idx(cmd_q.node_b), node_idx(cmd_q.node_a));
        wdata  = '{hops: 7'd1, next_hop: cmd_q.node_a};
      end
      default: begin
        if (ex_we) begin
          ram_we = 1'b1;
          waddr  = cell_addr(node_idx(cmd_q.node_b), ex_col_q);
          wdata  = '{hops: cand, next_hop: cmd_q.node_a};
        end
      end
    endcase
  end

  dvtu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (waddr),
    .wdata_i  (ENTRY_W'(wdata)),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  assign load_inst = cmd_pop_o && head_instant;
  assign load_rd   = (state_q == ST_RD_DATA) && out_free;
  assign inst_res  = (cmd_i.kind == KIND_DIAG) ?
                     result_t'{known: 1'b1, distance: '0, next_hop: cmd_i.node_a} : '0;
  assign rd_res    = (ent_a.hops == DIST_UNKNOWN) ? '0 :
                     result_t'{known: 1'b1, distance: ent_a.hops, next_hop: ent_a.next_hop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ex_valid_q <= (state_q == ST_ADV);
      if (load_inst || load_rd) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop_o) begin
            case (cmd_i.kind)
              KIND_LINK: state_q <= ST_LINK_AB;
              KIND_ADV: begin
                col_q   <= '0;
                state_q <= ST_ADV;
              end
              KIND_READ: state_q <= ST_RD_ADDR;
              default:   state_q <= ST_IDLE;
            endcase
          end
        end
        ST_LINK_AB:   state_q <= ST_LINK_BA;
        ST_LINK_BA:   state_q <= ST_IDLE;
        ST_ADV: begin
          col_q <= col_q + 1'b1;
          if (col_last) begin
            state_q <= ST_ADV_DRAIN;
          end
        end
        ST_ADV_DRAIN: state_q <= ST_IDLE;
        ST_RD_ADDR:   state_q <= ST_RD_DATA;
        ST_RD_DATA: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:      state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    ex_col_q <= col_q;
    if (load_inst) begin
      out_q <= inst_res;
    end else if (load_rd) begin
      out_q <= rd_res;
    end
  end

endmodule

### design/distance_vector_table_update.sv
// ----------------------------------------------------------------------------
// distance_vector_table_update
// Distance / next-hop table for nodes 1..node_count with link, advertise and
// read commands.
// ----------------------------------------------------------------------------
// Channels: input words enter on push/full (accepted when push is high and
// full low); read results leave on empty/pop (result_o is valid while empty
// is low, taken when pop is high). node_count is written on the cfg channel,
// which is always ready.
// Steps per command, once it reaches the back end:
//   link       two table writes, a->b then b->a
//   advertise  one destination per cycle through the
//              two-read, one-write table RAM
//   read       address, then data into the result register once it is free;
//              diagonal or out-of-range reads load that register directly
// Words that make no change are dropped at the front in the accept cycle.
// A four-entry command queue lets input words keep arriving while a result
// waits; when the result is not popped the back end holds at the next read
// and the queue fills, then full rises.
// Reset: the table is swept to unknown, one entry per cycle, min(MAX_NODES,
// 127)^2 entries (4096 at the default); full stays high for the whole sweep.
// ----------------------------------------------------------------------------
module distance_vector_table_update import dvtu_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  item_t             item_i,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output result_t           result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [NODE_W-1:0] cfg_data_i
);

  localparam int ROWS = (MAX_NODES < 127) ? MAX_NODES : 127;

  logic [NODE_W-1:0] node_count_q, n_eff;
  logic              clearing, cmd_valid, cmd_pop, out_valid;
  cmd_t              cmd;

  assign cfg_ready_o = 1'b1;
  assign n_eff       = (node_count_q > NODE_W'(ROWS)) ? NODE_W'(ROWS) : node_count_q;
  assign empty       = !out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  dvtu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_eff_i     (n_eff),
    .clearing_i  (clearing),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  dvtu_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_eff_i     (n_eff),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid),
    .out_o       (result_o),
    .out_pop_i   (pop)
  );

endmodule

### design/dvtu_checker.sv
// ----------------------------------------------------------------------------
// dvtu_checker
// Port-level checks on the result channel of the table update block.
// ----------------------------------------------------------------------------
`include "distance_vector_table_update_defines.svh"

module dvtu_checker import dvtu_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    empty,
  input logic    pop,
  input result_t result_o
);

  `DVTU_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result_o), "result word dropped or changed while stalled")
  `DVTU_ASSERT_NOW(a_known_route, !empty && result_o.known, (result_o.next_hop != '0) && (result_o.distance != DIST_UNKNOWN), "known route with no next hop or unknown distance")
  `DVTU_ASSERT_NOW(a_unknown_zero, !empty && !result_o.known, (result_o.distance == '0) && (result_o.next_hop == '0), "unknown route carries nonzero fields")

endmodule

bind distance_vector_table_update dvtu_checker u_dvtu_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
